[rtl/core/rpa_pkg.sv]
// shared widths, request and status codes, and controller/datapath structs
// for the ring pool allocator; no dependencies
package rpa_pkg;

  localparam int REQ_W      = 2;
  localparam int SIZE_W     = 17;
  localparam int OFF_W      = 16;
  localparam int REC_W      = 17;
  localparam int STAT_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam int POOL_BYTES_DEF  = 65536;
  localparam int QUEUE_DEPTH_DEF = 64;

  localparam logic [REQ_W-1:0] REQ_ALLOC   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PUBLISH = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TAKE    = 2'd2;
  localparam logic [REQ_W-1:0] REQ_RECYCLE = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
  localparam logic [STAT_W-1:0] ST_NO_SPACE    = 3'd1;
  localparam logic [STAT_W-1:0] ST_TOO_LARGE   = 3'd2;
  localparam logic [STAT_W-1:0] ST_QUEUE_EMPTY = 3'd3;
  localparam logic [STAT_W-1:0] ST_QUEUE_FULL  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOTIFY_EN = 2'd1;

  // controller to datapath
  typedef struct packed {
    logic exec;       // request accepted this cycle
    logic take_load;  // load dequeued descriptor into the output register
  } rpa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic take_hit;   // current take request finds a pending descriptor
    logic mod_busy;   // release position remainder still in progress
  } rpa_stat_t;

endpackage

[rtl/core/ring_pool_allocator_with_event_queue.sv]
// top level of the ring pool allocator with descriptor queue
// depends on rpa_pkg, rpa_ctrl, rpa_datapath (which holds rpa_mod_unit)

// Hands out contiguous regions of a circular byte pool and keeps a FIFO of
// pending region descriptors; every request returns exactly one result.
// Allocate, publish and any failed request write their result straight into
// the output register, so the next request can be taken in the following
// cycle while the result is still held, unless out_stall holds that result.
// A successful take passes the registered descriptor memory read at the queue
// head and then the output register. A recycle writes its result straight
// into the output register, but in_stall stays high while the sequencer
// waits for the bit-serial remainder unit, which wraps the release position
// modulo the pool size (one quotient bit per cycle over the 18-bit sum); the
// sequencer returns to idle once it sees the unit no longer busy, and
// cfg_ready is low during that wait as well. Allocation never waits for space:
// a request that does not fit returns no_space and leaves all state alone, one
// larger than the pool returns too_large. Writing pool_size restarts the pool
// and empties the queue. Descriptor memory is not cleared at reset.
module ring_pool_allocator_with_event_queue #(
  parameter int POOL_BYTES  = rpa_pkg::POOL_BYTES_DEF,
  parameter int QUEUE_DEPTH = rpa_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [rpa_pkg::REQ_W-1:0]      in_req_type,
  input  logic [rpa_pkg::SIZE_W-1:0]     in_size,
  input  logic [rpa_pkg::OFF_W-1:0]      in_item_offset,
  input  logic [rpa_pkg::REC_W-1:0]      in_recycle_len,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rpa_pkg::STAT_W-1:0]     out_status,
  output logic [rpa_pkg::OFF_W-1:0]      out_region_offset,
  output logic [rpa_pkg::SIZE_W-1:0]     out_region_len,
  output logic [rpa_pkg::REC_W-1:0]      out_region_recycle,
  output logic                           out_arrival_notice,
  output logic [rpa_pkg::SIZE_W-1:0]     out_free_bytes,
  // config write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rpa_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rpa_pkg::*;

  rpa_cmd_t  dp_cmd;
  rpa_stat_t dp_stat;

  // sequencer: owns both handshakes and the output valid bit
  rpa_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cfg_ready   (cfg_ready),
    .stat        (dp_stat),
    .cmd         (dp_cmd)
  );

  // pool and queue state, arithmetic, descriptor memory, output payload
  rpa_datapath #(
    .POOL_BYTES  (POOL_BYTES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (dp_cmd),
    .stat               (dp_stat),
    .in_req_type        (in_req_type),
    .in_size            (in_size),
    .in_item_offset     (in_item_offset),
    .in_recycle_len     (in_recycle_len),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_status         (out_status),
    .out_region_offset  (out_region_offset),
    .out_region_len     (out_region_len),
    .out_region_recycle (out_region_recycle),
    .out_arrival_notice (out_arrival_notice),
    .out_free_bytes     (out_free_bytes)
  );

  // a take that finds a descriptor shows no result in the next cycle
  a_take_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_req_type == REQ_TAKE) && dp_stat.take_hit)
      |=> (!out_valid && in_stall))
    else $error("take result appeared before descriptor read");

  // free count never exceeds the largest pool
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_free_bytes <= SIZE_W'(POOL_BYTES)))
    else $error("free byte count above pool size");

  // failed requests carry no region
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK))
      |-> ((out_region_offset == '0) && (out_region_len == '0)
           && (out_region_recycle == '0) && !out_arrival_notice))
    else $error("error result with region fields set");

  // config is closed only during the recycle wrap, and then no request enters
  a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_ready |-> in_stall)
    else $error("config closed while requests are open");

endmodule

[rtl/core/rpa_mod_unit.sv]
// bit-serial remainder unit: dividend mod divisor, one bit per cycle
// depends on rpa_pkg
module rpa_mod_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [rpa_pkg::SIZE_W:0]   dividend,
  input  logic [rpa_pkg::SIZE_W-1:0] divisor,
  output logic                       busy,
  output logic                       done,
  output logic [rpa_pkg::OFF_W-1:0]  rem
);
  import rpa_pkg::*;

  localparam int STEPS = SIZE_W + 1;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [SIZE_W:0]  x_r;
  logic [SIZE_W-1:0] r_r;
  logic [SIZE_W-1:0] d_r;
  logic [SIZE_W:0]  shifted;
  logic [SIZE_W:0]  diff;
  logic [SIZE_W-1:0] r_nxt;

  always_comb begin
    shifted = {r_r, x_r[SIZE_W]};
    diff    = shifted - {1'b0, d_r};
    r_nxt   = (shifted >= {1'b0, d_r}) ? diff[SIZE_W-1:0] : shifted[SIZE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(STEPS);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= dividend;
      r_r <= '0;
      d_r <= divisor;
    end else if (busy_r) begin
      x_r <= {x_r[SIZE_W-1:0], 1'b0};
      r_r <= r_nxt;
    end
  end

  assign busy = busy_r;
  assign done = busy_r && (cnt_r == CNT_W'(1));
  // remainder stays below the pool size, so 16 bits hold it
  assign rem  = r_nxt[OFF_W-1:0];

endmodule

[rtl/core/rpa_datapath.sv]
// pool pointers, free count, descriptor queue memory, config registers and
// output register; depends on rpa_pkg and rpa_mod_unit
module rpa_datapath #(
  parameter int POOL_BYTES  = rpa_pkg::POOL_BYTES_DEF,
  parameter int QUEUE_DEPTH = rpa_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rpa_pkg::rpa_cmd_t              cmd,
  output rpa_pkg::rpa_stat_t             stat,
  input  logic [rpa_pkg::REQ_W-1:0]      in_req_type,
  input  logic [rpa_pkg::SIZE_W-1:0]     in_size,
  input  logic [rpa_pkg::OFF_W-1:0]      in_item_offset,
  input  logic [rpa_pkg::REC_W-1:0]      in_recycle_len,
  input  logic                           cfg_we,
  input  logic [rpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rpa_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [rpa_pkg::STAT_W-1:0]     out_status,
  output logic [rpa_pkg::OFF_W-1:0]      out_region_offset,
  output logic [rpa_pkg::SIZE_W-1:0]     out_region_len,
  output logic [rpa_pkg::REC_W-1:0]      out_region_recycle,
  output logic                           out_arrival_notice,
  output logic [rpa_pkg::SIZE_W-1:0]     out_free_bytes
);
  import rpa_pkg::*;

  localparam int QW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int ENT_W = OFF_W + SIZE_W + REC_W;
  localparam logic [SIZE_W-1:0] POOL_MAX = SIZE_W'(POOL_BYTES);

  // pool state
  logic [SIZE_W-1:0] pool_r;
  logic              notify_r;
  logic [SIZE_W-1:0] alloc_r, alloc_nxt;
  logic [OFF_W-1:0]  release_r;
  logic [SIZE_W-1:0] free_r, free_nxt;
  logic [QW-1:0]     head_r, head_nxt;
  logic [QW-1:0]     tail_r, tail_nxt;
  logic [CW-1:0]     count_r, count_nxt;

  // descriptor memory
  logic [ENT_W-1:0]  mem [QUEUE_DEPTH];
  logic [ENT_W-1:0]  rd_r;
  logic              wr_en;

  // result of the current request
  logic [STAT_W-1:0] o_status;
  logic [OFF_W-1:0]  o_off;
  logic [SIZE_W-1:0] o_len;
  logic [REC_W-1:0]  o_rec;
  logic              o_notice;
  logic              take_hit;

  // allocation arithmetic
  logic [SIZE_W:0]   alloc_sum;
  logic              fits;
  logic [SIZE_W-1:0] skipped;
  logic [SIZE_W:0]   need;
  logic [SIZE_W:0]   free_sum;
  logic [SIZE_W-1:0] pool_eff;

  // remainder unit
  logic              mod_start;
  logic              mod_busy;
  logic              mod_done;
  logic [OFF_W-1:0]  mod_rem;
  logic [SIZE_W:0]   rel_sum;

  always_comb begin
    if (cfg_data == '0) begin
      pool_eff = SIZE_W'(1);
    end else if (cfg_data > POOL_MAX) begin
      pool_eff = POOL_MAX;
    end else begin
      pool_eff = cfg_data;
    end
  end

  always_comb begin
    alloc_sum = {1'b0, alloc_r} + {1'b0, in_size};
    fits      = alloc_sum <= {1'b0, pool_r};
    // alloc_r never passes the pool size
    skipped   = pool_r - alloc_r;
    need      = fits ? {1'b0, in_size} : ({1'b0, skipped} + {1'b0, in_size});
    free_sum  = {1'b0, free_r} + {1'b0, in_recycle_len};
    rel_sum   = {2'b00, release_r} + {1'b0, in_recycle_len};
  end

  always_comb begin
    alloc_nxt = alloc_r;
    free_nxt  = free_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    wr_en     = 1'b0;
    mod_start = 1'b0;
    o_status  = ST_OK;
    o_off     = '0;
    o_len     = '0;
    o_rec     = '0;
    o_notice  = 1'b0;
    take_hit  = (in_req_type == REQ_TAKE) && (count_r != '0);
    case (in_req_type)
      REQ_ALLOC: begin
        if (in_size > pool_r) begin
          o_status = ST_TOO_LARGE;
        end else if ({1'b0, free_r} < need) begin
          o_status = ST_NO_SPACE;
        end else begin
          o_off     = fits ? alloc_r[OFF_W-1:0] : '0;
          o_len     = in_size;
          o_rec     = need[REC_W-1:0];
          alloc_nxt = fits ? alloc_sum[SIZE_W-1:0] : in_size;
          free_nxt  = free_r - need[SIZE_W-1:0];
        end
      end
      REQ_PUBLISH: begin
        if (count_r == CW'(QUEUE_DEPTH)) begin
          o_status = ST_QUEUE_FULL;
        end else begin
          wr_en     = 1'b1;
          tail_nxt  = (tail_r == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
          count_nxt = count_r + 1'b1;
          o_notice  = (count_r == '0) && notify_r;
        end
      end
      REQ_TAKE: begin
        if (!take_hit) begin
          o_status = ST_QUEUE_EMPTY;
        end else begin
          head_nxt  = (head_r == QW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
          count_nxt = count_r - 1'b1;
        end
      end
      REQ_RECYCLE: begin
        free_nxt  = (free_sum > {1'b0, pool_r}) ? pool_r : free_sum[SIZE_W-1:0];
        mod_start = 1'b1;
      end
      default: begin
      end
    endcase
  end

  rpa_mod_unit u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.exec && mod_start),
    .dividend (rel_sum),
    .divisor  (pool_r),
    .busy     (mod_busy),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_r    <= POOL_MAX;
      notify_r  <= 1'b0;
      alloc_r   <= '0;
      release_r <= '0;
      free_r    <= POOL_MAX;
      head_r    <= '0;
      tail_r    <= '0;
      count_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POOL_SIZE: begin
          // restart the pool
          pool_r    <= pool_eff;
          alloc_r   <= '0;
          release_r <= '0;
          free_r    <= pool_eff;
          head_r    <= '0;
          tail_r    <= '0;
          count_r   <= '0;
        end
        CFG_NOTIFY_EN: begin
          notify_r <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end else begin
      if (cmd.exec) begin
        alloc_r <= alloc_nxt;
        free_r  <= free_nxt;
        head_r  <= head_nxt;
        tail_r  <= tail_nxt;
        count_r <= count_nxt;
      end
      if (mod_done) begin
        release_r <= mod_rem;
      end
    end
  end

  // memory: one write port at tail, registered read at head
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[tail_r] <= {in_item_offset, in_size, in_recycle_len};
    end
    rd_r <= mem[head_r];
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.take_load) begin
      out_status         <= ST_OK;
      out_region_offset  <= rd_r[ENT_W-1 -: OFF_W];
      out_region_len     <= rd_r[REC_W +: SIZE_W];
      out_region_recycle <= rd_r[REC_W-1:0];
      out_arrival_notice <= 1'b0;
      out_free_bytes     <= free_r;
    end else if (cmd.exec && !take_hit) begin
      out_status         <= o_status;
      out_region_offset  <= o_off;
      out_region_len     <= o_len;
      out_region_recycle <= o_rec;
      out_arrival_notice <= o_notice;
      out_free_bytes     <= free_nxt;
    end
  end

  assign stat.take_hit = take_hit;
  assign stat.mod_busy = mod_busy;

endmodule

[rtl/core/rpa_ctrl.sv]
// request sequencer: handshakes, output valid, take and recycle wait states
// depends on rpa_pkg
module rpa_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [rpa_pkg::REQ_W-1:0] in_req_type,
  output logic                      in_stall,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      cfg_ready,
  input  rpa_pkg::rpa_stat_t        stat,
  output rpa_pkg::rpa_cmd_t         cmd
);
  import rpa_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_TAKE = 2'd1;
  localparam logic [1:0] S_MODW = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (stat.take_hit) begin
            state_nxt = S_TAKE;
          end else if (in_req_type == REQ_RECYCLE) begin
            state_nxt = S_MODW;
          end
        end
      end
      S_TAKE: begin
        state_nxt = S_IDLE;
      end
      S_MODW: begin
        if (!stat.mod_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if ((accept && !stat.take_hit) || (state_r == S_TAKE)) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign cfg_ready     = (state_r != S_MODW);
  assign cmd.exec      = accept;
  assign cmd.take_load = (state_r == S_TAKE);

endmodule
